FILE: src/otss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otss_pkg
// Shared types and constants of the one-shot timer set: command and result
// payloads, the timer entry that moves around the cell ring, and codes.
// ----------------------------------------------------------------------------
package otss_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned TICK_W    = 48;
  localparam int unsigned LIVE_W    = 5;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_CANCELLED = 3'd1,
    KIND_EXPIRED   = 3'd2,
    KIND_ZERO      = 3'd3,
    KIND_FULL      = 3'd4,
    KIND_NOTFOUND  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INS,
    ST_CAN,
    ST_EXP
  } state_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [DUR_W-1:0]  duration_ms;
    logic [ID_W-1:0]   cancel_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   timer_id;
    logic [DUR_W-1:0]  timer_duration;
    logic [TICK_W-1:0] timer_deadline;
    logic [LIVE_W-1:0] live_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DUR_W-1:0]  duration;
    logic [TICK_W-1:0] deadline;
  } entry_t;

endpackage : otss_pkg
`default_nettype wire

FILE: src/one_shot_timer_set_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// one_shot_timer_set_unit
// Up to DEPTH one-shot timers held in a rotating ring of cells, with a
// sequencer at the ring head for add, cancel and millisecond tick.
// ----------------------------------------------------------------------------
// Zero-duration and full adds answer in the cycle after the transfer.
// Add: one ring pass of id probing, then rotation until an empty slot.
// Cancel: rotation until the id matches, at most one ring pass. Tick: one
// ring pass per expired timer plus one, each result right after its pass.
// The receiver cannot stall; busy blocks new starts.
// Reset clears all slot valid bits, the id counter and the tick time at once.
module one_shot_timer_set_unit
  import otss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire cmd_t cmd_i,
  output logic      busy,
  output logic      result_valid_o,
  output result_t   result_o
);

  entry_t ring[DEPTH];
  entry_t wb;
  logic   shift;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      otss_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .ent_i  (wb),
        .ent_o  (ring[i])
      );
    end else begin : g_mid
      otss_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(shift),
        .ent_i  (ring[i+1]),
        .ent_o  (ring[i])
      );
    end
  end

  otss_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .cmd_i         (cmd_i),
    .busy_o        (busy),
    .head_i        (ring[0]),
    .shift_o       (shift),
    .wb_o          (wb),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

`ifndef ASSERT_OFF
  // a tick always starts a ring pass
  a_tick_scans : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.func == FUNC_TICK) |=> busy)
    else $error("tick transfer did not start a pass");

  // a non-final result only occurs mid-tick, so more passes follow
  a_more_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy)
    else $error("non-final result while idle");

  // rejected adds never start a pass
  a_reject_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((result_o.kind == KIND_ZERO) || (result_o.kind == KIND_FULL))
    |-> !busy && result_o.last)
    else $error("rejected add left the unit busy");
`endif

endmodule : one_shot_timer_set_unit
`default_nettype wire

FILE: src/otss_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otss_cell
// One timer slot of the ring. While the ring rotates it takes the entry of
// its neighbor; the valid bit is cleared by reset.
// ----------------------------------------------------------------------------
module otss_cell
  import otss_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   shift_i,
  input  wire entry_t ent_i,
  output entry_t      ent_o
);

  logic              valid_q;
  logic [ID_W-1:0]   id_q;
  logic [DUR_W-1:0]  dur_q;
  logic [TICK_W-1:0] dl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= ent_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      id_q  <= ent_i.id;
      dur_q <= ent_i.duration;
      dl_q  <= ent_i.deadline;
    end
  end

  assign ent_o = '{valid: valid_q, id: id_q, duration: dur_q, deadline: dl_q};

endmodule : otss_cell
`default_nettype wire

FILE: src/otss_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// otss_ctrl
// Sequencer at the head of the cell ring. Every pass rotates the ring once
// and looks at one entry per cycle: id probe and insert for add, match for
// cancel, earliest-due search and removal for tick.
// ----------------------------------------------------------------------------
module otss_ctrl
  import otss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire cmd_t   cmd_i,
  output logic        busy_o,
  input  wire entry_t head_i,
  output logic        shift_o,
  output entry_t      wb_o,
  output logic        result_valid_o,
  output result_t     result_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     count_q, count_d;
  logic [ID_W-1:0]   next_id_q, next_id_d;
  logic [TICK_W-1:0] now_q, now_d;
  logic [ID_W-1:0]   cand_q, cand_d;
  logic [ID_W-1:0]   cid_q, cid_d;
  logic [DUR_W-1:0]  new_dur_q, new_dur_d;
  logic [TICK_W-1:0] new_dl_q, new_dl_d;
  logic [DEPTH-1:0]  mask_q, mask_d;
  logic              found_q, found_d;
  logic              more_q, more_d;
  entry_t            best_q, best_d;
  logic              rm_pend_q, rm_pend_d;
  logic [ID_W-1:0]   rm_id_q, rm_id_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  logic              pass_end;
  logic [ID_W-1:0]   off;
  logic [IW-1:0]     fz;
  logic              remove;
  logic              due;
  logic              better;
  logic              found_n;
  logic              more_n;
  entry_t            best_n;

  assign pass_end = (cnt_q == IW'(DEPTH - 1));
  assign off      = head_i.id - cand_q;

  // first free id offset from the candidate
  always_comb begin
    fz = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!mask_q[i]) begin
        fz = IW'(i);
      end
    end
  end

  // earliest-due search at the ring head
  always_comb begin
    remove  = rm_pend_q && head_i.valid && (head_i.id == rm_id_q);
    due     = head_i.valid && !remove && (head_i.deadline <= now_q);
    better  = !found_q || (head_i.deadline < best_q.deadline) ||
              ((head_i.deadline == best_q.deadline) && (head_i.id < best_q.id));
    found_n = found_q | due;
    more_n  = more_q | (due & found_q);
    best_n  = (due && better) ? head_i : best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      next_id_q   <= '0;
      now_q       <= '0;
      found_q     <= 1'b0;
      more_q      <= 1'b0;
      rm_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      now_q       <= now_d;
      found_q     <= found_d;
      more_q      <= more_d;
      rm_pend_q   <= rm_pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q    <= cand_d;
    cid_q     <= cid_d;
    new_dur_q <= new_dur_d;
    new_dl_q  <= new_dl_d;
    mask_q    <= mask_d;
    best_q    <= best_d;
    rm_id_q   <= rm_id_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    next_id_d   = next_id_q;
    now_d       = now_q;
    cand_d      = cand_q;
    cid_d       = cid_q;
    new_dur_d   = new_dur_q;
    new_dl_d    = new_dl_q;
    mask_d      = mask_q;
    found_d     = found_q;
    more_d      = more_q;
    best_d      = best_q;
    rm_pend_d   = rm_pend_q;
    rm_id_d     = rm_id_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    wb_o        = head_i;
    shift_o     = (state_q != ST_IDLE);

    if (shift_o) begin
      cnt_d = pass_end ? '0 : cnt_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          unique case (func_e'(cmd_i.func))
            FUNC_ADD: begin
              if (cmd_i.duration_ms == '0) begin
                res_valid_d = 1'b1;
                res_d       = '{kind: KIND_ZERO, timer_id: '0, timer_duration: '0,
                                timer_deadline: '0, live_count: LIVE_W'(count_q),
                                last: 1'b1};
              end else if (count_q == CW'(DEPTH)) begin
                res_valid_d = 1'b1;
                res_d       = '{kind: KIND_FULL, timer_id: '0, timer_duration: '0,
                                timer_deadline: '0, live_count: LIVE_W'(count_q),
                                last: 1'b1};
              end else begin
                next_id_d = next_id_q + 1'b1;
                cand_d    = next_id_q;
                new_dur_d = cmd_i.duration_ms;
                new_dl_d  = now_q + TICK_W'(cmd_i.duration_ms);
                mask_d    = '0;
                state_d   = ST_SCAN;
              end
            end
            FUNC_CANCEL: begin
              cid_d   = cmd_i.cancel_id;
              state_d = ST_CAN;
            end
            FUNC_TICK: begin
              now_d     = now_q + 1'b1;
              found_d   = 1'b0;
              more_d    = 1'b0;
              rm_pend_d = 1'b0;
              state_d   = ST_EXP;
            end
            default: begin
            end
          endcase
        end
      end

      // mark which of the next DEPTH ids are taken
      ST_SCAN: begin
        if (head_i.valid && (off < ID_W'(DEPTH))) begin
          mask_d[off[IW-1:0]] = 1'b1;
        end
        if (pass_end) begin
          state_d = ST_INS;
        end
      end

      // first empty slot reaching the head takes the new timer
      ST_INS: begin
        if (!head_i.valid) begin
          wb_o        = '{valid: 1'b1, id: cand_q + ID_W'(fz), duration: new_dur_q,
                          deadline: new_dl_q};
          count_d     = count_q + 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_ADDED, timer_id: cand_q + ID_W'(fz),
                          timer_duration: new_dur_q, timer_deadline: new_dl_q,
                          live_count: LIVE_W'(count_q + 1'b1), last: 1'b1};
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end
      end

      ST_CAN: begin
        if (head_i.valid && (head_i.id == cid_q)) begin
          wb_o.valid  = 1'b0;
          count_d     = count_q - 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_CANCELLED, timer_id: head_i.id,
                          timer_duration: head_i.duration,
                          timer_deadline: head_i.deadline,
                          live_count: LIVE_W'(count_q - 1'b1), last: 1'b1};
          cnt_d       = '0;
          state_d     = ST_IDLE;
        end else if (pass_end) begin
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_NOTFOUND, timer_id: cid_q, timer_duration: '0,
                          timer_deadline: '0, live_count: LIVE_W'(count_q),
                          last: 1'b1};
          state_d     = ST_IDLE;
        end
      end

      // one expired timer per pass, freed during the following pass
      ST_EXP: begin
        wb_o.valid = head_i.valid & ~remove;
        if (!pass_end) begin
          found_d = found_n;
          more_d  = more_n;
          best_d  = best_n;
        end else if (found_n) begin
          count_d     = count_q - 1'b1;
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_EXPIRED, timer_id: best_n.id,
                          timer_duration: best_n.duration,
                          timer_deadline: best_n.deadline,
                          live_count: LIVE_W'(count_q - 1'b1), last: ~more_n};
          rm_id_d     = best_n.id;
          rm_pend_d   = 1'b1;
          found_d     = 1'b0;
          more_d      = 1'b0;
        end else begin
          rm_pend_d = 1'b0;
          found_d   = 1'b0;
          more_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule : otss_ctrl
`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for one_shot_timer_set_unit. A driver feeds add, cancel,
// tick and unused commands from a queue; a shadow copy of the timer set works
// out every expected result; a monitor checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import otss_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_CMDS = 84;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  cmd_t    cmd_i  = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  one_shot_timer_set_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .cmd_i         (cmd_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow timer set
  logic              held          [DEPTH];
  logic [ID_W-1:0]   held_id       [DEPTH];
  logic [DUR_W-1:0]  held_dur      [DEPTH];
  logic [TICK_W-1:0] held_deadline [DEPTH];
  logic [ID_W-1:0]   id_counter = '0;
  logic [TICK_W-1:0] ms_now     = '0;

  cmd_t        pending_cmds [$];
  result_t     due_events   [$];
  int unsigned cmds_sent     = 0;
  int unsigned events_seen   = 0;
  int unsigned n_errors      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned gap_left      = 0;
  int unsigned biggest_burst = 0;
  int unsigned kind_seen [8] = '{default: 0};

  function automatic cmd_t timer_cmd(func_e f, logic [DUR_W-1:0] d, logic [ID_W-1:0] id);
    cmd_t c;
    c.func        = f;
    c.duration_ms = d;
    c.cancel_id   = id;
    return c;
  endfunction

  function automatic int unsigned held_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (held[i]) n++;
    end
    return n;
  endfunction

  function automatic bit id_taken(logic [ID_W-1:0] id);
    for (int i = 0; i < DEPTH; i++) begin
      if (held[i] && held_id[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // live count is taken after the state change of the result
  function automatic result_t timer_event(kind_e k, logic [ID_W-1:0] id,
                                          logic [DUR_W-1:0] dur,
                                          logic [TICK_W-1:0] dl, logic last);
    result_t r;
    r.kind           = k;
    r.timer_id       = id;
    r.timer_duration = dur;
    r.timer_deadline = dl;
    r.live_count     = LIVE_W'(held_count());
    r.last           = last;
    return r;
  endfunction

  task automatic advance_timer_set(input cmd_t c);
    int              slot;
    int              best;
    int unsigned     burst;
    logic [ID_W-1:0] cand;
    result_t         held_back;
    bit              have_held_back;
    slot           = -1;
    best           = -1;
    burst          = 0;
    have_held_back = 1'b0;
    case (func_e'(c.func))
      FUNC_ADD: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!held[i] && slot < 0) slot = i;
        end
        if (c.duration_ms == '0) begin
          due_events.push_back(timer_event(KIND_ZERO, '0, '0, '0, 1'b1));
        end else if (slot < 0) begin
          due_events.push_back(timer_event(KIND_FULL, '0, '0, '0, 1'b1));
        end else begin
          cand       = id_counter;
          id_counter = id_counter + 1'b1;
          for (int p = 0; p < DEPTH && id_taken(cand); p++) cand = cand + 1'b1;
          held[slot]          = 1'b1;
          held_id[slot]       = cand;
          held_dur[slot]      = c.duration_ms;
          held_deadline[slot] = ms_now + TICK_W'(c.duration_ms);
          due_events.push_back(timer_event(KIND_ADDED, cand, c.duration_ms,
                                           held_deadline[slot], 1'b1));
        end
      end
      FUNC_CANCEL: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (held[i] && held_id[i] == c.cancel_id && slot < 0) slot = i;
        end
        if (slot < 0) begin
          due_events.push_back(timer_event(KIND_NOTFOUND, c.cancel_id, '0, '0, 1'b1));
        end else begin
          held[slot] = 1'b0;
          due_events.push_back(timer_event(KIND_CANCELLED, held_id[slot], held_dur[slot],
                                           held_deadline[slot], 1'b1));
        end
      end
      FUNC_TICK: begin
        ms_now = ms_now + 1'b1;
        // earliest deadline first, ties to the lower id; last flag goes on the final one
        do begin
          best = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (held[i] && held_deadline[i] <= ms_now &&
                (best < 0 || held_deadline[i] < held_deadline[best] ||
                 (held_deadline[i] == held_deadline[best] && held_id[i] < held_id[best])))
              best = i;
          end
          if (best >= 0) begin
            held[best] = 1'b0;
            if (have_held_back) due_events.push_back(held_back);
            held_back      = timer_event(KIND_EXPIRED, held_id[best], held_dur[best],
                                         held_deadline[best], 1'b0);
            have_held_back = 1'b1;
            burst++;
          end
        end while (best >= 0);
        if (have_held_back) begin
          held_back.last = 1'b1;
          due_events.push_back(held_back);
        end
        if (burst > biggest_burst) biggest_burst = burst;
      end
      default: begin
      end
    endcase
  endtask

  // command driver
  always @(posedge clk_i) begin : drive_cmds
    bit          fire;
    int unsigned roll;
    fire = rst_ni && start && !busy;
    roll = $urandom_range(0, 99);
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (fire) begin
        advance_timer_set(cmd_i);
        cmds_sent++;
      end
      if (fire || !start) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_cmds.size() != 0) begin
          cmd_i <= pending_cmds.pop_front();
          start <= 1'b1;
          // back-to-back through the directed list and the first random commands, then mostly short gaps
          if (cmds_sent < 30 || roll < 50) gap_left <= 0;
          else if (roll < 85) gap_left <= $urandom_range(1, 3);
          else if (roll < 97) gap_left <= $urandom_range(4, 12);
          else gap_left <= $urandom_range(20, 60);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                      logic [TICK_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin : watch_results
    result_t want;
    if (rst_ni && result_valid_o) begin
      events_seen++;
      kind_seen[result_o.kind]++;
      if (due_events.size() == 0) begin
        $error("unexpected result: kind %0d, id %0h", result_o.kind, result_o.timer_id);
        n_errors++;
      end else begin
        want = due_events.pop_front();
        check_field("kind", TICK_W'(want.kind), TICK_W'(result_o.kind));
        check_field("timer_id", TICK_W'(want.timer_id), TICK_W'(result_o.timer_id));
        check_field("timer_duration", TICK_W'(want.timer_duration),
                    TICK_W'(result_o.timer_duration));
        check_field("timer_deadline", want.timer_deadline, result_o.timer_deadline);
        check_field("live_count", TICK_W'(want.live_count), TICK_W'(result_o.live_count));
        check_field("last", TICK_W'(want.last), TICK_W'(result_o.last));
      end
    end
  end

  // watchdog on cycles with no transfer in either direction
  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || result_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cmd_t              c;
    logic [DUR_W-1:0]  dur;
    logic [ID_W-1:0]   cid;
    logic [ID_W-1:0]   live_ids [$];
    int unsigned       counted;
    int unsigned       roll;
    int unsigned       pick;
    bit                fill;
    counted = 0;
    for (int i = 0; i < DEPTH; i++) held[i] = 1'b0;

    pending_cmds.push_back(timer_cmd(FUNC_TICK, $urandom, 16'($urandom)));   // quiet tick
    pending_cmds.push_back(timer_cmd(FUNC_NONE, 32'hFFFF_FFFF, 16'hFFFF));
    pending_cmds.push_back(timer_cmd(FUNC_ADD, '0, 16'hFFFF));               // zero duration
    pending_cmds.push_back(timer_cmd(FUNC_CANCEL, '0, 16'hFFFF));            // unknown id
    pending_cmds.push_back(timer_cmd(FUNC_ADD, 32'hFFFF_FFFF, '0));
    pending_cmds.push_back(timer_cmd(FUNC_CANCEL, 32'hFFFF_FFFF, 16'd0));
    for (int i = 0; i < DEPTH; i++) pending_cmds.push_back(timer_cmd(FUNC_ADD, 32'd1, '0));
    pending_cmds.push_back(timer_cmd(FUNC_ADD, 32'd5, '0));                  // set full
    pending_cmds.push_back(timer_cmd(FUNC_CANCEL, '0, 16'd1));
    // reuses the lowest slot with the highest id, so slot order and id order differ
    pending_cmds.push_back(timer_cmd(FUNC_ADD, 32'd1, '0));
    pending_cmds.push_back(timer_cmd(FUNC_TICK, '0, '0));                    // all due at once

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0);

    // alternate fill-heavy and drain-heavy stretches
    while (counted < RANDOM_CMDS) begin
      fill = ((counted / 20) % 2) == 0;
      roll = $urandom_range(0, 99);
      dur  = $urandom;
      cid  = 16'($urandom);
      if (roll < 4) begin
        c = timer_cmd(FUNC_NONE, dur, cid);
      end else if (roll < (fill ? 64 : 34)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) dur = '0;
        else if (pick < 7) dur = $urandom_range(1, 6);
        else if (pick < 9) dur = $urandom_range(1, 40);
        c = timer_cmd(FUNC_ADD, dur, cid);
      end else if (roll < (fill ? 76 : 54)) begin
        live_ids.delete();
        for (int i = 0; i < DEPTH; i++) begin
          if (held[i]) live_ids.push_back(held_id[i]);
        end
        if (live_ids.size() != 0 && $urandom_range(0, 3) != 0)
          cid = live_ids[$urandom_range(0, live_ids.size() - 1)];
        c = timer_cmd(FUNC_CANCEL, dur, cid);
      end else begin
        c = timer_cmd(FUNC_TICK, dur, cid);
      end
      if (c.func != FUNC_NONE) counted++;
      pending_cmds.push_back(c);
      wait (pending_cmds.size() == 0);
    end

    @(posedge clk_i);
    while (start || due_events.size() != 0) @(posedge clk_i);
    repeat (4 * DEPTH + 8) @(posedge clk_i);

    $display("%0d commands: %0d added, %0d cancelled, %0d expired, largest expiry burst %0d",
             cmds_sent, kind_seen[KIND_ADDED], kind_seen[KIND_CANCELLED],
             kind_seen[KIND_EXPIRED], biggest_burst);
    $display("%0d zero-duration, %0d full, %0d unknown-id; %0d results, %0d mismatches",
             kind_seen[KIND_ZERO], kind_seen[KIND_FULL], kind_seen[KIND_NOTFOUND],
             events_seen, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
